/* src/rsdp_pkg.sv */
package rsdp_pkg;

   // Largest row width that the one-bit unpacker supports.
   localparam int MaxWidth = 4096;

   // Field and register widths.
   localparam int SampleWidth   = 16;
   localparam int ChromaWidth   = 8;
   localparam int ColorWidth    = 8;
   localparam int ModeWidth     = 2;
   localparam int RowWidthBits  = 13;
   localparam int MinimumWidth  = 16;
   localparam int GainWidth     = 24;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 24;

   // Pixels unpacked from one packed byte, and the count that holds it.
   localparam int BitsPerByte = 8;
   localparam int PixelCountWidth = $clog2(BitsPerByte + 1);

   // The row width clamp, limited to what the row width register can hold.
   localparam logic [RowWidthBits-1:0] MaxWidthClamp =
      (MaxWidth > (2 ** RowWidthBits) - 1) ? {RowWidthBits{1'b1}} : RowWidthBits'(MaxWidth);

   // Reset values of the configuration registers.
   localparam logic [RowWidthBits-1:0] RowWidthReset  = 13'd640;
   localparam logic [MinimumWidth-1:0] MinimumReset   = 16'd0;
   localparam logic [GainWidth-1:0]    GainReset      = 24'd4081;

   // Q2.14 color conversion coefficients.
   localparam logic signed [15:0] CoefBu = 16'sd29049;
   localparam logic signed [15:0] CoefGu = 16'sd5636;
   localparam logic signed [15:0] CoefGv = 16'sd11698;
   localparam logic signed [15:0] CoefRv = 16'sd22987;

   typedef enum logic [ModeWidth-1:0] {
      ModeGrey   = 2'd0,
      ModeNv16   = 2'd1,
      ModeOneBit = 2'd2,
      ModeNorm   = 2'd3
   } pixel_mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrPixelMode    = 2'd0,
      CsrRowWidth     = 2'd1,
      CsrRangeMinimum = 2'd2,
      CsrRangeGain    = 2'd3
   } csr_index_type;

endpackage

/* src/rsdp_channels.sv */
// Request channel: one raw sample with its chroma pair.
interface rsdp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [rsdp_pkg::SampleWidth-1:0]     sample;
   logic [rsdp_pkg::ChromaWidth-1:0]     chroma_u;
   logic [rsdp_pkg::ChromaWidth-1:0]     chroma_v;

   modport source (output valid, output sample, output chroma_u, output chroma_v,
                   input ready);
   modport sink (input valid, input sample, input chroma_u, input chroma_v,
                 output ready);
endinterface

// Response channel: one display pixel.
interface rsdp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [rsdp_pkg::ColorWidth-1:0]      blue;
   logic [rsdp_pkg::ColorWidth-1:0]      green;
   logic [rsdp_pkg::ColorWidth-1:0]      red;
   logic                                 last;

   modport source (output valid, output blue, output green, output red, output last,
                   input ready);
   modport sink (input valid, input blue, input green, input red, input last,
                 output ready);
endinterface

/* src/raw_sensor_pixel_to_display.sv */
// Raw sensor pixel to display pixel converter.
//
// Each request on the req channel carries one raw sample (plus the U and V of
// its pair in NV16 mode). The block answers with display pixels on the rsp
// channel as blue, green and red bytes; last marks the final pixel of a request.
// The mode register selects grey passthrough, NV16 to BGR conversion, one-bit
// unpacking (up to eight pixels per byte, cut at the row end) or normalization
// of a 16-bit sample with a Q8.16 gain.
//
// The datapath is two registers deep: the request register and the output
// register, with the multipliers, rounding and saturation between them. The
// first pixel of a request passes through the request register and then the
// output register before it appears on rsp. One request is accepted per cycle
// while the pipeline does not stall; a one-bit request holds the output register
// until its last unpacked pixel is taken.
//
// When the receiver stalls, each stage holds its contents and req.ready falls
// once both stages are full. Reset empties the pipeline, loads the configuration
// registers with their defaults and clears the row column count. Configuration
// writes are expected only while no request is in flight.
module raw_sensor_pixel_to_display (
   input  logic                                  clock,
   input  logic                                  reset,
   rsdp_req_if.sink                              req,
   rsdp_rsp_if.source                            rsp,
   input  logic                                  csr_write_enable,
   input  logic [rsdp_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [rsdp_pkg::CsrDataWidth-1:0]     csr_write_data
);

   // Configuration registers.
   rsdp_pkg::pixel_mode_type                  pixel_mode_ff;
   logic [rsdp_pkg::RowWidthBits-1:0]         row_width_ff;
   logic [rsdp_pkg::MinimumWidth-1:0]         range_minimum_ff;
   logic [rsdp_pkg::GainWidth-1:0]            range_gain_ff;

   // Pixels of the current row already claimed by accepted one-bit requests.
   logic [rsdp_pkg::RowWidthBits-1:0]         column_count_ff;
   logic [rsdp_pkg::RowWidthBits-1:0]         column_count_in;

   // Request register.
   logic                                      p1_valid_ff;
   rsdp_pkg::pixel_mode_type                  p1_mode_ff;
   logic [rsdp_pkg::SampleWidth-1:0]          p1_sample_ff;
   logic [rsdp_pkg::ChromaWidth-1:0]          p1_chroma_u_ff;
   logic [rsdp_pkg::ChromaWidth-1:0]          p1_chroma_v_ff;
   logic [rsdp_pkg::PixelCountWidth-1:0]      p1_count_ff;

   // Output register.
   logic                                      out_valid_ff;
   logic [rsdp_pkg::ColorWidth-1:0]           out_blue_ff;
   logic [rsdp_pkg::ColorWidth-1:0]           out_green_ff;
   logic [rsdp_pkg::ColorWidth-1:0]           out_red_ff;
   logic [rsdp_pkg::BitsPerByte-2:0]          out_bits_ff;
   logic [rsdp_pkg::PixelCountWidth-1:0]      out_left_ff;

   // Handshake between the stages.
   logic out_final;
   logic out_take;
   logic p1_ready;
   logic req_accept;

   // Row bookkeeping for the one-bit mode, worked out at acceptance.
   logic [rsdp_pkg::RowWidthBits-1:0]         width_eff;
   logic [rsdp_pkg::RowWidthBits-1:0]         col_start;
   logic [rsdp_pkg::RowWidthBits-1:0]         col_remain;
   logic [rsdp_pkg::RowWidthBits-1:0]         col_sum;
   logic [rsdp_pkg::PixelCountWidth-1:0]      pixel_count;

   // Products.
   logic signed [8:0]                         chroma_u_s;
   logic signed [8:0]                         chroma_v_s;
   logic [16:0]                               norm_diff;
   logic [39:0]                               norm_prod;
   logic signed [24:0]                        prod_bu;
   logic signed [24:0]                        prod_gu;
   logic signed [24:0]                        prod_gv;
   logic signed [24:0]                        prod_rv;

   // Rounding and saturation.
   logic signed [25:0]                        yuv_base;
   logic signed [25:0]                        t_blue;
   logic signed [25:0]                        t_green;
   logic signed [25:0]                        t_red;
   logic [40:0]                               t_norm;
   logic [rsdp_pkg::ColorWidth-1:0]           norm_pixel;
   logic [rsdp_pkg::ColorWidth-1:0]           unpack_first;
   logic [rsdp_pkg::ColorWidth-1:0]           blue_in;
   logic [rsdp_pkg::ColorWidth-1:0]           green_in;
   logic [rsdp_pkg::ColorWidth-1:0]           red_in;

   // Clamp a Q14 value to a byte: negative gives zero, overflow gives 255.
   function automatic logic [7:0] sat_q14(input logic signed [25:0] t);
      logic [7:0] result;
      if (t[25]) begin
         result = 8'd0;
      end else if (|t[24:22]) begin
         result = 8'hFF;
      end else begin
         result = t[21:14];
      end
      return result;
   endfunction

   // ------------------------------------------------------------------
   // Configuration port.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff    <= rsdp_pkg::ModeGrey;
         row_width_ff     <= rsdp_pkg::RowWidthReset;
         range_minimum_ff <= rsdp_pkg::MinimumReset;
         range_gain_ff    <= rsdp_pkg::GainReset;
      end else if (csr_write_enable) begin
         unique case (rsdp_pkg::csr_index_type'(csr_index))
            rsdp_pkg::CsrPixelMode: begin
               pixel_mode_ff <= rsdp_pkg::pixel_mode_type'(csr_write_data[rsdp_pkg::ModeWidth-1:0]);
            end
            rsdp_pkg::CsrRowWidth: begin
               row_width_ff <= csr_write_data[rsdp_pkg::RowWidthBits-1:0];
            end
            rsdp_pkg::CsrRangeMinimum: begin
               range_minimum_ff <= csr_write_data[rsdp_pkg::MinimumWidth-1:0];
            end
            rsdp_pkg::CsrRangeGain: begin
               range_gain_ff <= csr_write_data[rsdp_pkg::GainWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage handshake. A stage can load when it is empty or when the stage
   // after it takes its contents in the same cycle.
   // ------------------------------------------------------------------
   assign out_final  = (out_left_ff == rsdp_pkg::PixelCountWidth'(1));
   assign out_take   = !out_valid_ff || (rsp.ready && out_final);
   assign p1_ready   = !p1_valid_ff || out_take;
   assign req.ready  = p1_ready;
   assign req_accept = req.valid && p1_ready;

   // ------------------------------------------------------------------
   // Row bookkeeping. A zero width counts as one, a width beyond the
   // supported maximum is clamped, and a column count that already sits at
   // or past the width (after the width was lowered) starts a new row.
   // ------------------------------------------------------------------
   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = rsdp_pkg::RowWidthBits'(1);
      end else if (row_width_ff > rsdp_pkg::MaxWidthClamp) begin
         width_eff = rsdp_pkg::MaxWidthClamp;
      end else begin
         width_eff = row_width_ff;
      end

      col_start  = (column_count_ff >= width_eff) ? '0 : column_count_ff;
      col_remain = width_eff - col_start;
      if (col_remain > rsdp_pkg::RowWidthBits'(rsdp_pkg::BitsPerByte)) begin
         pixel_count = rsdp_pkg::PixelCountWidth'(rsdp_pkg::BitsPerByte);
      end else begin
         pixel_count = col_remain[rsdp_pkg::PixelCountWidth-1:0];
      end
      col_sum = col_start + rsdp_pkg::RowWidthBits'(pixel_count);

      column_count_in = column_count_ff;
      if (req_accept && (pixel_mode_ff == rsdp_pkg::ModeOneBit)) begin
         column_count_in = (col_sum >= width_eff) ? '0 : col_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
      end else begin
         column_count_ff <= column_count_in;
      end
   end

   // ------------------------------------------------------------------
   // Request register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_ready) begin
         p1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_mode_ff     <= pixel_mode_ff;
         p1_sample_ff   <= req.sample;
         p1_chroma_u_ff <= req.chroma_u;
         p1_chroma_v_ff <= req.chroma_v;
         // Non-packed modes always give exactly one pixel.
         p1_count_ff    <= (pixel_mode_ff == rsdp_pkg::ModeOneBit) ?
                           pixel_count : rsdp_pkg::PixelCountWidth'(1);
      end
   end

   // ------------------------------------------------------------------
   // Products: chroma products for NV16 and the gain product for
   // normalization.
   // ------------------------------------------------------------------
   assign chroma_u_s = $signed({1'b0, p1_chroma_u_ff}) - 9'sd128;
   assign chroma_v_s = $signed({1'b0, p1_chroma_v_ff}) - 9'sd128;
   assign norm_diff  = {1'b0, p1_sample_ff} - {1'b0, range_minimum_ff};
   assign norm_prod  = norm_diff[15:0] * range_gain_ff;
   assign prod_bu    = rsdp_pkg::CoefBu * chroma_u_s;
   assign prod_gu    = rsdp_pkg::CoefGu * chroma_u_s;
   assign prod_gv    = rsdp_pkg::CoefGv * chroma_v_s;
   assign prod_rv    = rsdp_pkg::CoefRv * chroma_v_s;

   // ------------------------------------------------------------------
   // Rounding, saturation and mode selection.
   // ------------------------------------------------------------------
   always_comb begin
      // Luma in Q14 with the rounding half already added.
      yuv_base = $signed({4'b0000, p1_sample_ff[7:0], 1'b1, 13'd0});
      t_blue   = yuv_base + 26'(prod_bu);
      t_green  = yuv_base - 26'(prod_gu) - 26'(prod_gv);
      t_red    = yuv_base + 26'(prod_rv);

      t_norm = {1'b0, norm_prod} + 41'd32768;
      if (norm_diff[16]) begin
         norm_pixel = 8'd0;
      end else if (|t_norm[40:24]) begin
         norm_pixel = 8'hFF;
      end else begin
         norm_pixel = t_norm[23:16];
      end

      unpack_first = p1_sample_ff[0] ? 8'hFF : 8'h00;

      case (p1_mode_ff)
         rsdp_pkg::ModeNv16: begin
            blue_in  = sat_q14(t_blue);
            green_in = sat_q14(t_green);
            red_in   = sat_q14(t_red);
         end
         rsdp_pkg::ModeOneBit: begin
            blue_in  = unpack_first;
            green_in = unpack_first;
            red_in   = unpack_first;
         end
         rsdp_pkg::ModeNorm: begin
            blue_in  = norm_pixel;
            green_in = norm_pixel;
            red_in   = norm_pixel;
         end
         default: begin
            blue_in  = p1_sample_ff[7:0];
            green_in = p1_sample_ff[7:0];
            red_in   = p1_sample_ff[7:0];
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Output register. A packed byte stays here until its last pixel is taken;
   // on each taken pixel the remaining bits shift down, least significant first.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_take) begin
         out_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         if (p1_valid_ff) begin
            out_blue_ff  <= blue_in;
            out_green_ff <= green_in;
            out_red_ff   <= red_in;
            out_bits_ff  <= p1_sample_ff[7:1];
            out_left_ff  <= p1_count_ff;
         end
      end else if (rsp.ready) begin
         out_blue_ff  <= out_bits_ff[0] ? 8'hFF : 8'h00;
         out_green_ff <= out_bits_ff[0] ? 8'hFF : 8'h00;
         out_red_ff   <= out_bits_ff[0] ? 8'hFF : 8'h00;
         out_bits_ff  <= out_bits_ff >> 1;
         out_left_ff  <= out_left_ff - rsdp_pkg::PixelCountWidth'(1);
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.blue  = out_blue_ff;
   assign rsp.green = out_green_ff;
   assign rsp.red   = out_red_ff;
   assign rsp.last  = out_final;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // The column count never reaches the largest supported row width.
   assert property (@(posedge clock) disable iff (reset)
      column_count_ff < rsdp_pkg::MaxWidthClamp)
      else $error("column count beyond the maximum row width");

   // A pixel on offer always has between one and eight pixels left in its request.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (out_left_ff != '0) &&
                    (out_left_ff <= rsdp_pkg::PixelCountWidth'(rsdp_pkg::BitsPerByte)))
      else $error("output pixel count out of range");

   // Taking a pixel that is not the last one leaves the rest of the request on offer.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !rsp.last |=>
         rsp.valid && (out_left_ff == $past(out_left_ff) - rsdp_pkg::PixelCountWidth'(1)))
      else $error("unpacked pixels lost");

   // Only one-bit requests move the column count.
   assert property (@(posedge clock) disable iff (reset)
      !(req_accept && (pixel_mode_ff == rsdp_pkg::ModeOneBit)) |=> $stable(column_count_ff))
      else $error("column count changed without a one-bit request");

   // The request side stalls only when both stages are occupied.
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> p1_valid_ff && out_valid_ff)
      else $error("request stalled with an empty stage");

endmodule
